// ----- hdl/tdr_pkg.sv -----
// shared constants, event codes and scaling factors for the touch report decoder
package tdr_pkg;

    localparam int FINGER_SLOTS = 2;
    localparam int SCREEN_COLS  = 144;
    localparam int SCREEN_ROWS  = 168;

    // packet identifiers
    localparam logic [7:0] ID_TOUCH = 8'h5A;
    localparam logic [7:0] ID_PALM  = 8'h BA;
    localparam logic [7:0] ID_HELLO = 8'h55;

    // event codes
    localparam logic [2:0] EV_DOWN       = 3'd0;
    localparam logic [2:0] EV_UP         = 3'd1;
    localparam logic [2:0] EV_PALM       = 3'd2;
    localparam logic [2:0] EV_RESET      = 3'd3;
    localparam logic [2:0] EV_UNEXPECTED = 3'd4;

    // active window of the raw coordinates
    localparam int COL_LO   = 220;
    localparam int COL_HI   = 820;
    localparam int ROW_LO   = 120;
    localparam int ROW_HI   = 820;
    localparam int COL_SPAN = COL_HI - COL_LO;
    localparam int ROW_SPAN = ROW_HI - ROW_LO;

    // widths: offset < 700, screen size <= 1024, product < 2^20, quotient < 2^11
    localparam int W_OFS   = 10;
    localparam int W_SCR   = 11;
    localparam int W_PROD  = 20;
    localparam int W_QUO   = 11;
    localparam int REC_SHIFT = W_PROD;
    localparam int W_REC   = 11;

    // floor reciprocals; the quotient they give is low by at most one
    localparam int COL_REC = (1 << REC_SHIFT) / COL_SPAN;
    localparam int ROW_REC = (1 << REC_SHIFT) / ROW_SPAN;

    typedef struct packed {
        logic             valid;
        logic [2:0]       kind;
        logic             slot;
        logic             down;
        logic             last;
    } t_ctrl;

endpackage

// ----- hdl/touch_report_decoder.sv -----
// touch report decoder: sorts a report by identifier and scales finger coordinates
// timing: a result passes from the held request through the stage 1, 2 and 3 registers to the outputs;
// a touch's second result follows in the next cycle. A touch request holds off the next request while busy is high
// for one cycle, any other can be followed at once; the single result port carries one finger slot per cycle
// reset: synchronous active-low i_rst_n clears the held request and all stage valid bits
// results cannot be stalled by the receiver; o_valid marks each one for a single cycle
module touch_report_decoder
    import tdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_packet_kind,
    input  logic [7:0] i_f0_high_nibbles,
    input  logic [7:0] i_f0_x_low,
    input  logic [7:0] i_f0_y_low,
    input  logic [7:0] i_f1_high_nibbles,
    input  logic [7:0] i_f1_x_low,
    input  logic [7:0] i_f1_y_low,
    input  logic [7:0] i_finger_mask,
    output logic       o_valid,
    output logic [2:0] o_event_kind,
    output logic       o_finger_slot,
    output logic [7:0] o_screen_x,
    output logic [7:0] o_screen_y,
    output logic       o_last_of_run
);

    localparam logic [W_SCR-1:0]    COLS_C  = W_SCR'(SCREEN_COLS);
    localparam logic [W_SCR-1:0]    ROWS_C  = W_SCR'(SCREEN_ROWS);
    localparam logic [W_REC-1:0]    COL_REC_C = W_REC'(COL_REC);
    localparam logic [W_REC-1:0]    ROW_REC_C = W_REC'(ROW_REC);
    localparam logic [W_OFS-1:0]    COL_SPAN_C = W_OFS'(COL_SPAN);
    localparam logic [W_OFS-1:0]    ROW_SPAN_C = W_OFS'(ROW_SPAN);
    localparam logic [11:0]         COL_LO_C = 12'(COL_LO);
    localparam logic [11:0]         COL_MAX_C = 12'(COL_HI - 1);
    localparam logic [11:0]         ROW_LO_C = 12'(ROW_LO);
    localparam logic [11:0]         ROW_MAX_C = 12'(ROW_HI - 1);
    localparam logic                MULTI_SLOT = (FINGER_SLOTS > 1);
    localparam logic                LAST_SLOT = 1'(FINGER_SLOTS - 1);

    // ---------------- stage 0: held request, one finger slot per cycle
    logic       r_hold_v;
    logic       r_slot;
    logic [7:0] r_kind;
    logic [7:0] r_hi0, r_xl0, r_yl0, r_hi1, r_xl1, r_yl1, r_mask;
    logic       accept;
    logic       n_hold_v;
    logic       n_slot;

    assign busy   = r_hold_v && (r_kind == ID_TOUCH) && !r_slot && MULTI_SLOT;
    assign accept = start && !busy;

    always_comb begin
        n_hold_v = r_hold_v;
        n_slot   = r_slot;
        if (accept) begin
            n_hold_v = 1'b1;
            n_slot   = 1'b0;
        end else if (busy) begin
            n_slot   = 1'b1;
        end else begin
            n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_slot   <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_slot   <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_packet_kind;
            r_hi0  <= i_f0_high_nibbles;
            r_xl0  <= i_f0_x_low;
            r_yl0  <= i_f0_y_low;
            r_hi1  <= i_f1_high_nibbles;
            r_xl1  <= i_f1_x_low;
            r_yl1  <= i_f1_y_low;
            r_mask <= i_finger_mask;
        end
    end

    // ---------------- stage 1: classify, unpack, swap axes, clip
    t_ctrl            n_c1, r_c1;
    logic [W_OFS-1:0] n_cx, n_cy, r_cx, r_cy;
    logic [7:0]       sel_hi, sel_al, sel_bl;
    logic [11:0]      raw_a, raw_b;

    always_comb begin
        sel_hi = r_slot ? r_hi1 : r_hi0;
        sel_al = r_slot ? r_xl1 : r_xl0;
        sel_bl = r_slot ? r_yl1 : r_yl0;
        raw_a  = {sel_hi[7:4], sel_al};
        raw_b  = {sel_hi[3:0], sel_bl};

        if (raw_b < COL_LO_C)       n_cx = '0;
        else if (raw_b > COL_MAX_C) n_cx = W_OFS'(COL_MAX_C - COL_LO_C);
        else                        n_cx = W_OFS'(raw_b - COL_LO_C);

        if (raw_a < ROW_LO_C)       n_cy = '0;
        else if (raw_a > ROW_MAX_C) n_cy = W_OFS'(ROW_MAX_C - ROW_LO_C);
        else                        n_cy = W_OFS'(raw_a - ROW_LO_C);

        n_c1.valid = r_hold_v;
        n_c1.slot  = 1'b0;
        n_c1.down  = 1'b0;
        n_c1.last  = 1'b1;
        if (r_kind == ID_TOUCH) begin
            n_c1.slot = r_slot;
            n_c1.down = r_mask[r_slot];
            n_c1.kind = r_mask[r_slot] ? EV_DOWN : EV_UP;
            n_c1.last = (r_slot == LAST_SLOT);
        end else if (r_kind == ID_PALM) begin
            n_c1.kind = EV_PALM;
        end else if (r_kind == ID_HELLO) begin
            n_c1.kind = EV_RESET;
        end else begin
            n_c1.kind = EV_UNEXPECTED;
        end
    end

    // ---------------- stage 2: scale by screen size
    t_ctrl             r_c2;
    logic [W_PROD-1:0] r_px, r_py;

    // ---------------- stage 3: reciprocal multiply, estimate low by at most one
    t_ctrl             r_c3;
    logic [W_PROD-1:0] r_px3, r_py3;
    logic [W_QUO-1:0]  r_qx, r_qy;
    logic [W_PROD+W_REC-1:0] mx, my;

    assign mx = (W_PROD+W_REC)'(r_px) * (W_PROD+W_REC)'(COL_REC_C);
    assign my = (W_PROD+W_REC)'(r_py) * (W_PROD+W_REC)'(ROW_REC_C);

    // ---------------- stage 4: remainder correction and row inversion
    logic [W_PROD-1:0] rem_x, rem_y;
    logic [W_QUO-1:0]  qx, qy;
    logic [W_SCR-1:0]  inv_y;

    always_comb begin
        rem_x = r_px3 - W_PROD'(r_qx * W_PROD'(COL_SPAN_C));
        rem_y = r_py3 - W_PROD'(r_qy * W_PROD'(ROW_SPAN_C));
        qx    = (rem_x >= W_PROD'(COL_SPAN_C)) ? r_qx + 1'b1 : r_qx;
        qy    = (rem_y >= W_PROD'(ROW_SPAN_C)) ? r_qy + 1'b1 : r_qy;
        inv_y = ROWS_C - W_SCR'(1) - W_SCR'(qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
            r_c2.valid <= 1'b0;
            r_c3.valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_c1.valid <= n_c1.valid;
            r_c2.valid <= r_c1.valid;
            r_c3.valid <= r_c2.valid;
            o_valid    <= r_c3.valid;
        end

        r_c1.kind <= n_c1.kind;
        r_c1.slot <= n_c1.slot;
        r_c1.down <= n_c1.down;
        r_c1.last <= n_c1.last;
        r_cx      <= n_cx;
        r_cy      <= n_cy;

        r_c2.kind <= r_c1.kind;
        r_c2.slot <= r_c1.slot;
        r_c2.down <= r_c1.down;
        r_c2.last <= r_c1.last;
        r_px      <= W_PROD'(r_cx * W_PROD'(COLS_C));
        r_py      <= W_PROD'(r_cy * W_PROD'(ROWS_C));

        r_c3.kind <= r_c2.kind;
        r_c3.slot <= r_c2.slot;
        r_c3.down <= r_c2.down;
        r_c3.last <= r_c2.last;
        r_px3     <= r_px;
        r_py3     <= r_py;
        r_qx      <= mx[REC_SHIFT +: W_QUO];
        r_qy      <= my[REC_SHIFT +: W_QUO];

        o_event_kind  <= r_c3.kind;
        o_finger_slot <= r_c3.slot;
        o_last_of_run <= r_c3.last;
        o_screen_x    <= r_c3.down ? qx[7:0] : 8'd0;
        o_screen_y    <= r_c3.down ? inv_y[7:0] : 8'd0;
    end

endmodule

// ----- tb/tb_touch_report_decoder.sv -----
// self-checking testbench for the touch report decoder
module tb_touch_report_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import tdr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_COUNT = 680;

    typedef struct {
        logic [7:0] kind;
        logic [7:0] high_nib [2];
        logic [7:0] x_low [2];
        logic [7:0] y_low [2];
        logic [7:0] mask;
    } t_touch_report;

    typedef struct {
        logic [2:0] kind;
        logic       slot;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } t_touch_event;

    class t_report_scoreboard;
        t_touch_event expected_q[$];
        int error_count;

        task report_mismatch(string what, int got_v, int exp_v);
            $display("[%0t] touch event mismatch on %s: got %0d, expected %0d",
                $realtime, what, got_v, exp_v);
            error_count++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // clip to [lo, hi-1], take the offset, scale by size/span
        function int scale_axis(int raw, int lo, int hi, int size);
            int v;
            v = raw;
            if (v < lo) v = lo;
            if (v > hi - 1) v = hi - 1;
            return ((v - lo) * size) / (hi - lo);
        endfunction

        function void note_request(t_touch_report r);
            t_touch_event ev;
            int raw_a;
            int raw_b;
            int row;
            if (r.kind != ID_TOUCH) begin
                ev.kind = (r.kind == ID_PALM) ? EV_PALM :
                          (r.kind == ID_HELLO) ? EV_RESET : EV_UNEXPECTED;
                ev.slot = 1'b0;
                ev.col  = 8'd0;
                ev.row  = 8'd0;
                ev.last = 1'b1;
                expected_q.push_back(ev);
                return;
            end
            for (int i = 0; i < FINGER_SLOTS && i < 2; i++) begin
                ev.slot = 1'(i);
                ev.last = (i + 1 == FINGER_SLOTS || i == 1);
                if (r.mask[i]) begin
                    // raw A feeds the rows, raw B the columns
                    raw_a = {r.high_nib[i][7:4], r.x_low[i]};
                    raw_b = {r.high_nib[i][3:0], r.y_low[i]};
                    row = SCREEN_ROWS - 1 - scale_axis(raw_a, ROW_LO, ROW_HI, SCREEN_ROWS);
                    ev.kind = EV_DOWN;
                    ev.col  = 8'(scale_axis(raw_b, COL_LO, COL_HI, SCREEN_COLS));
                    ev.row  = 8'(row);
                end else begin
                    ev.kind = EV_UP;
                    ev.col  = 8'd0;
                    ev.row  = 8'd0;
                end
                expected_q.push_back(ev);
            end
        endfunction

        task check_event(t_touch_event got);
            t_touch_event exp_ev;
            if (expected_q.size() == 0) begin
                report_mismatch("unrequested event kind", got.kind, -1);
                return;
            end
            exp_ev = expected_q.pop_front();
            if (got.kind !== exp_ev.kind) report_mismatch("event_kind", got.kind, exp_ev.kind);
            if (got.slot !== exp_ev.slot) report_mismatch("finger_slot", got.slot, exp_ev.slot);
            if (got.col !== exp_ev.col) report_mismatch("screen_x", got.col, exp_ev.col);
            if (got.row !== exp_ev.row) report_mismatch("screen_y", got.row, exp_ev.row);
            if (got.last !== exp_ev.last) report_mismatch("last_of_run", got.last, exp_ev.last);
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_packet_kind;
    logic [7:0] i_f0_high_nibbles;
    logic [7:0] i_f0_x_low;
    logic [7:0] i_f0_y_low;
    logic [7:0] i_f1_high_nibbles;
    logic [7:0] i_f1_x_low;
    logic [7:0] i_f1_y_low;
    logic [7:0] i_finger_mask;
    logic       o_valid;
    logic [2:0] o_event_kind;
    logic       o_finger_slot;
    logic [7:0] o_screen_x;
    logic [7:0] o_screen_y;
    logic       o_last_of_run;

    t_report_scoreboard sb = new;
    int stall_cycles;

    touch_report_decoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_packet_kind     (i_packet_kind),
        .i_f0_high_nibbles (i_f0_high_nibbles),
        .i_f0_x_low        (i_f0_x_low),
        .i_f0_y_low        (i_f0_y_low),
        .i_f1_high_nibbles (i_f1_high_nibbles),
        .i_f1_x_low        (i_f1_x_low),
        .i_f1_y_low        (i_f1_y_low),
        .i_finger_mask     (i_finger_mask),
        .o_valid           (o_valid),
        .o_event_kind      (o_event_kind),
        .o_finger_slot     (o_finger_slot),
        .o_screen_x        (o_screen_x),
        .o_screen_y        (o_screen_y),
        .o_last_of_run     (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request capture, event checking and the stall watchdog
    always @(posedge i_clk) begin
        t_touch_report req;
        t_touch_event  got;
        if (i_rst_n) begin
            if (start && !busy) begin
                req.kind        = i_packet_kind;
                req.high_nib[0] = i_f0_high_nibbles;
                req.x_low[0]    = i_f0_x_low;
                req.y_low[0]    = i_f0_y_low;
                req.high_nib[1] = i_f1_high_nibbles;
                req.x_low[1]    = i_f1_x_low;
                req.y_low[1]    = i_f1_y_low;
                req.mask        = i_finger_mask;
                sb.note_request(req);
            end
            if (o_valid === 1'b1) begin
                got.kind = o_event_kind;
                got.slot = o_finger_slot;
                got.col  = o_screen_x;
                got.row  = o_screen_y;
                got.last = o_last_of_run;
                sb.check_event(got);
            end
            if ((start && !busy) || o_valid === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("touch_report_decoder regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(t_touch_report r);
        i_packet_kind     <= r.kind;
        i_f0_high_nibbles <= r.high_nib[0];
        i_f0_x_low        <= r.x_low[0];
        i_f0_y_low        <= r.y_low[0];
        i_f1_high_nibbles <= r.high_nib[1];
        i_f1_x_low        <= r.x_low[1];
        i_f1_y_low        <= r.y_low[1];
        i_finger_mask     <= r.mask;
        start             <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every outstanding event has come back
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_touch_report make_touch(logic [7:0] mask, int a0, int b0,
                                                 int a1, int b1);
        t_touch_report r;
        logic [11:0] a [2];
        logic [11:0] b [2];
        a[0] = 12'(a0);
        b[0] = 12'(b0);
        a[1] = 12'(a1);
        b[1] = 12'(b1);
        r.kind = ID_TOUCH;
        r.mask = mask;
        for (int i = 0; i < 2; i++) begin
            r.high_nib[i] = {a[i][11:8], b[i][11:8]};
            r.x_low[i]    = a[i][7:0];
            r.y_low[i]    = b[i][7:0];
        end
        return r;
    endfunction

    function automatic t_touch_report make_packet(logic [7:0] kind);
        t_touch_report r;
        r = make_touch(8'($urandom), $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095));
        r.kind = kind;
        return r;
    endfunction

    // mostly inside the window, some anywhere, some right on the clip edges
    function automatic int pick_coord(int lo);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom_range(0, 4095);
        if (sel < 8)
            return $urandom_range(lo, 819);
        case ($urandom_range(0, 5))
            0: return lo - 1;
            1: return lo;
            2: return 819;
            3: return 820;
            4: return 0;
            default: return 4095;
        endcase
    endfunction

    function automatic t_touch_report random_report();
        int sel;
        logic [7:0] kind;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return make_touch(8'($urandom), pick_coord(ROW_LO), pick_coord(COL_LO),
                              pick_coord(ROW_LO), pick_coord(COL_LO));
        if (sel < 80)
            return make_packet(ID_PALM);
        if (sel < 85)
            return make_packet(ID_HELLO);
        kind = 8'($urandom);
        return make_packet(kind);
    endfunction

    task automatic run_directed();
        send_request(make_touch(8'h00, 500, 500, 500, 500));
        send_request(make_touch(8'h03, 0, 0, 0, 0));
        send_request(make_touch(8'h03, 4095, 4095, 4095, 4095));
        send_request(make_touch(8'h03, 120, 220, 819, 819));
        send_request(make_touch(8'h03, 119, 219, 820, 820));
        send_request(make_touch(8'h01, 470, 520, 300, 700));
        send_request(make_touch(8'h02, 470, 520, 300, 700));
        // mask bits above the slot count are ignored
        send_request(make_touch(8'hFC, 470, 520, 300, 700));
        send_request(make_touch(8'hFF, 12'hABC, 12'h123, 12'h5A5, 12'hA5A));
        send_request(make_packet(ID_PALM));
        send_request(make_packet(ID_HELLO));
        // a hello does not halt the decoder
        send_request(make_touch(8'h03, 600, 400, 200, 800));
        send_request(make_packet(8'h00));
        send_request(make_packet(8'hFF));
        send_request(make_packet(8'h5B));
        send_request(make_packet(8'hA5));
    endtask

    initial begin
        start             <= 1'b0;
        i_packet_kind     <= 8'd0;
        i_f0_high_nibbles <= 8'd0;
        i_f0_x_low        <= 8'd0;
        i_f0_y_low        <= 8'd0;
        i_f1_high_nibbles <= 8'd0;
        i_f1_x_low        <= 8'd0;
        i_f1_y_low        <= 8'd0;
        i_finger_mask     <= 8'd0;
        i_rst_n           <= 1'b0;
        stall_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_results();

        for (int k = 0; k < RANDOM_COUNT; k++) begin
            if (k % 170 == 169)
                drain_results();
            // no random idle gaps for items 250 to 399, apart from the drain at item 339
            if ((k < 250 || k >= 400) && $urandom_range(0, 99) < 22)
                idle_cycles($urandom_range(1, 4));
            send_request(random_report());
        end

        drain_results();
        repeat (12) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("touch_report_decoder regression: pass");
        else
            $display("touch_report_decoder regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tdr_pkg.sv
hdl/touch_report_decoder.sv
tb/tb_touch_report_decoder.sv
